// ----- sv/xsr_pkg.sv -----
// ----------------------------------------------------------------------------
// xsr_pkg
// Shared widths, operation codes and the job record passed from the
// accumulating front end to the result back end of cross_section_reduce.
// ----------------------------------------------------------------------------
package xsr_pkg;

	localparam int VALUE_BITS = 32;
	localparam int ACC_BITS   = 48;
	localparam int CNT_BITS   = 17;
	localparam int STEP_BITS  = $clog2(ACC_BITS);

	localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
	localparam logic [CNT_BITS-1:0]        COUNT_MAX = {CNT_BITS{1'b1}};

	localparam logic [2:0] OP_SUM       = 3'd0;
	localparam logic [2:0] OP_MEAN      = 3'd1;
	localparam logic [2:0] OP_MAX       = 3'd2;
	localparam logic [2:0] OP_MIN       = 3'd3;
	localparam logic [2:0] OP_RANK_DESC = 3'd4;
	localparam logic [2:0] OP_RANK_ASC  = 3'd5;

	typedef enum logic [1:0] {
		KIND_PASS = 2'd0,
		KIND_DIV  = 2'd1,
		KIND_INCR = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t                   kind;
		logic signed [ACC_BITS-1:0]  value;
		logic                        valid;
		logic [CNT_BITS-1:0]         count;
	} job_t;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_DIV  = 3'b010,
		B_DONE = 3'b100
	} back_state_t;

endpackage

// ----- sv/xsr_front.sv -----
// ----------------------------------------------------------------------------
// xsr_front
// Accumulates one date's members, one word per accepted cycle, and on the last
// member, classifies the result and hands a job to the back end.
// ----------------------------------------------------------------------------
module xsr_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [2:0]                        cfg_data,
	input  logic                              accept,
	input  logic signed [31:0]                member_value,
	input  logic                              member_present,
	input  logic signed [31:0]                reference_value,
	input  logic                              reference_active,
	input  logic                              group_last,
	output logic                              push,
	output xsr_pkg::job_t                     job
);

	logic [2:0]                               op_q;
	logic signed [xsr_pkg::ACC_BITS-1:0]      acc_q;
	logic                                     seen_q;
	logic [xsr_pkg::CNT_BITS-1:0]             cnt_q;
	logic                                     ovf_q;

	logic signed [xsr_pkg::ACC_BITS-1:0]      v48;
	logic signed [xsr_pkg::ACC_BITS-1:0]      r48;
	logic signed [xsr_pkg::ACC_BITS:0]        sum49;
	logic signed [xsr_pkg::ACC_BITS-1:0]      sum_sat;
	logic                                     sum_ovf;
	logic                                     acc_room;
	logic signed [xsr_pkg::ACC_BITS-1:0]      acc_d;
	logic                                     seen_d;
	logic [xsr_pkg::CNT_BITS-1:0]             cnt_d;
	logic                                     ovf_d;

	assign v48 = xsr_pkg::ACC_BITS'($signed(member_value[xsr_pkg::VALUE_BITS-1:0]));
	assign r48 = xsr_pkg::ACC_BITS'($signed(reference_value[xsr_pkg::VALUE_BITS-1:0]));

	assign sum49 = {acc_q[xsr_pkg::ACC_BITS-1], acc_q} + {v48[xsr_pkg::ACC_BITS-1], v48};
	assign sum_ovf = sum49[xsr_pkg::ACC_BITS] != sum49[xsr_pkg::ACC_BITS-1];
	assign sum_sat = !sum_ovf ? sum49[xsr_pkg::ACC_BITS-1:0]
		: (sum49[xsr_pkg::ACC_BITS] ? xsr_pkg::ACC_MIN : xsr_pkg::ACC_MAX);
	assign acc_room = acc_q < xsr_pkg::ACC_MAX;

	// state after this member
	always_comb begin
		acc_d  = acc_q;
		seen_d = seen_q;
		cnt_d  = cnt_q;
		ovf_d  = ovf_q;
		if (member_present) begin
			case (op_q)
				xsr_pkg::OP_SUM, xsr_pkg::OP_MEAN: begin
					acc_d = sum_sat;
					if (sum_ovf) ovf_d = 1'b1;
				end
				xsr_pkg::OP_MAX: begin
					if (!seen_q || v48 > acc_q) acc_d = v48;
				end
				xsr_pkg::OP_MIN: begin
					if (!seen_q || v48 < acc_q) acc_d = v48;
				end
				xsr_pkg::OP_RANK_DESC: begin
					if (v48 > r48 && acc_room) acc_d = acc_q + 1'b1;
				end
				xsr_pkg::OP_RANK_ASC: begin
					if (v48 < r48 && acc_room) acc_d = acc_q + 1'b1;
				end
				default: begin
				end
			endcase
			seen_d = 1'b1;
			if (cnt_q != xsr_pkg::COUNT_MAX) cnt_d = cnt_q + 1'b1;
		end
	end

	// classify the finished date
	always_comb begin
		job.kind  = xsr_pkg::KIND_PASS;
		job.value = '0;
		job.valid = 1'b0;
		job.count = cnt_d;
		case (op_q)
			xsr_pkg::OP_SUM, xsr_pkg::OP_MAX, xsr_pkg::OP_MIN: begin
				if (seen_d) begin
					job.value = acc_d;
					job.valid = 1'b1;
				end
			end
			xsr_pkg::OP_MEAN: begin
				if (seen_d) begin
					job.kind  = xsr_pkg::KIND_DIV;
					job.value = acc_d;
					job.valid = 1'b1;
				end
			end
			xsr_pkg::OP_RANK_DESC, xsr_pkg::OP_RANK_ASC: begin
				if (reference_active) begin
					job.kind  = xsr_pkg::KIND_INCR;
					job.value = acc_d;
					job.valid = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign push = accept && group_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= xsr_pkg::OP_SUM;
			acc_q  <= '0;
			seen_q <= 1'b0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else begin
			if (cfg_valid) op_q <= cfg_data;
			if (accept) begin
				if (group_last) begin
					// clear for the next date
					acc_q  <= '0;
					seen_q <= 1'b0;
					cnt_q  <= '0;
					ovf_q  <= 1'b0;
				end else begin
					acc_q  <= acc_d;
					seen_q <= seen_d;
					cnt_q  <= cnt_d;
					ovf_q  <= ovf_d;
				end
			end
		end
	end

endmodule

// ----- sv/xsr_queue.sv -----
// ----------------------------------------------------------------------------
// xsr_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
module xsr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  xsr_pkg::job_t  push_job,
	input  logic           pop,
	output xsr_pkg::job_t  head,
	output logic           empty,
	output logic           full
);

	xsr_pkg::job_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;
	logic          do_push;
	logic          do_pop;

	assign empty   = fill_q == 2'd0;
	assign full    = fill_q == 2'd2;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ----- sv/xsr_back.sv -----
// ----------------------------------------------------------------------------
// xsr_back
// Finishes each job: passes it through, adds one for a rank, or runs a
// bit-serial restoring divide for a mean, then holds it in the output register.
// ----------------------------------------------------------------------------
module xsr_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  xsr_pkg::job_t                     head,
	input  logic                              empty,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [47:0]                result_value,
	output logic                              result_valid,
	output logic [16:0]                       present_count
);

	xsr_pkg::back_state_t                     state_q;
	logic                                     out_valid_q;
	logic signed [xsr_pkg::ACC_BITS-1:0]      res_q;
	logic                                     res_valid_q;
	logic [xsr_pkg::CNT_BITS-1:0]             res_cnt_q;

	logic [xsr_pkg::ACC_BITS-1:0]             quo_q;
	logic [xsr_pkg::CNT_BITS-1:0]             rem_q;
	logic [xsr_pkg::CNT_BITS-1:0]             div_q;
	logic                                     neg_q;
	logic [xsr_pkg::STEP_BITS-1:0]            step_q;

	logic                                     out_free;
	logic                                     load_out;
	logic [xsr_pkg::CNT_BITS:0]               rem_sh;
	logic                                     ge;
	logic [xsr_pkg::CNT_BITS:0]               rem_sub;
	logic [xsr_pkg::ACC_BITS-1:0]             mag;
	logic signed [xsr_pkg::ACC_BITS-1:0]      incr_val;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == xsr_pkg::B_IDLE) && !empty && out_free;
	assign load_out = (pop && head.kind != xsr_pkg::KIND_DIV)
		|| (state_q == xsr_pkg::B_DONE && out_free);

	assign rem_sh  = {rem_q, quo_q[xsr_pkg::ACC_BITS-1]};
	assign ge      = rem_sh >= {1'b0, div_q};
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign mag     = head.value[xsr_pkg::ACC_BITS-1] ? -head.value : head.value;
	assign incr_val = (head.value < xsr_pkg::ACC_MAX) ? head.value + 1'b1 : xsr_pkg::ACC_MAX;

	always_ff @(posedge clk) begin
		case (state_q)
			xsr_pkg::B_IDLE: begin
				if (pop) begin
					res_cnt_q   <= head.count;
					res_valid_q <= head.valid;
					case (head.kind)
						xsr_pkg::KIND_INCR: res_q <= incr_val;
						xsr_pkg::KIND_DIV: begin
							quo_q <= mag;
							rem_q <= '0;
							div_q <= head.count;
							neg_q <= head.value[xsr_pkg::ACC_BITS-1];
						end
						default: res_q <= head.value;
					endcase
				end
			end
			xsr_pkg::B_DIV: begin
				quo_q <= {quo_q[xsr_pkg::ACC_BITS-2:0], ge};
				rem_q <= ge ? rem_sub[xsr_pkg::CNT_BITS-1:0] : rem_sh[xsr_pkg::CNT_BITS-1:0];
			end
			xsr_pkg::B_DONE: begin
				// truncate toward zero: negate the magnitude quotient
				if (out_free) res_q <= neg_q ? -$signed(quo_q) : $signed(quo_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= xsr_pkg::B_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				xsr_pkg::B_IDLE: begin
					if (pop && head.kind == xsr_pkg::KIND_DIV) begin
						state_q <= xsr_pkg::B_DIV;
						step_q  <= '0;
					end
				end
				xsr_pkg::B_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == xsr_pkg::STEP_BITS'(xsr_pkg::ACC_BITS - 1)) begin
						state_q <= xsr_pkg::B_DONE;
					end
				end
				xsr_pkg::B_DONE: begin
					if (out_free) begin
						state_q <= xsr_pkg::B_IDLE;
					end
				end
				default: state_q <= xsr_pkg::B_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign result_value  = res_q;
	assign result_valid  = res_valid_q;
	assign present_count = res_cnt_q;

endmodule

// ----- sv/cross_section_reduce.sv -----
// ----------------------------------------------------------------------------
// cross_section_reduce
// Reduces the members of one date to a sum, mean, max, min or rank.
//
// Input channel (in_valid / in_stall) carries one member word per cycle
// while in_stall is low; the word with group_last set closes the date and
// yields one result on the output channel (out_valid / out_stall). Words
// without group_last yield nothing. The mode register is written on
// cfg_valid with cfg_ready always high; write it only while the block is idle.
//
// The front end takes one member per cycle unless the input stalls. A
// closed date goes into a two-entry job queue; the input stalls only
// while that queue is full. Sum, max, min, rank and the invalid cases
// pass from the queue into the output register. Mean runs a
// bit-serial divider of 48 steps in the back end, which takes no new
// job from the queue until the quotient is in the output register. A
// stalled result holds in the output register while the front end keeps
// accumulating until the queue fills. Reset clears the mode to sum,
// empties the queue and the accumulator.
// ----------------------------------------------------------------------------
module cross_section_reduce (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [31:0]  member_value,
	input  logic                member_present,
	input  logic signed [31:0]  reference_value,
	input  logic                reference_active,
	input  logic                group_last,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [47:0]  result_value,
	output logic                result_valid,
	output logic [16:0]         present_count
);

	xsr_pkg::job_t push_job;
	xsr_pkg::job_t head;
	logic          push;
	logic          pop;
	logic          empty;
	logic          full;
	logic          accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;
	assign accept    = in_valid && !in_stall;

	xsr_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_data         (cfg_data),
		.accept           (accept),
		.member_value     (member_value),
		.member_present   (member_present),
		.reference_value  (reference_value),
		.reference_active (reference_active),
		.group_last       (group_last),
		.push             (push),
		.job              (push_job)
	);

	xsr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	xsr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_value  (result_value),
		.result_valid  (result_valid),
		.present_count (present_count)
	);

endmodule

// ----- sim/tb_cross_section_reduce.sv -----
// ----------------------------------------------------------------------------
// tb_cross_section_reduce
// Self-checking bench for the cross-section reducer. A queue-fed driver
// offers member words and a monitor checks every date result against an
// in-bench predictor of sum, mean, max, min and rank. The run covers
// directed corner dates and random dates under every mode, with random
// idling on both channels and one long output hold.
// ----------------------------------------------------------------------------
module tb_cross_section_reduce;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [31:0] value;
		logic               present;
		logic signed [31:0] ref_value;
		logic               ref_active;
		logic               last;
	} member_word_t;

	typedef struct packed {
		logic signed [47:0] value;
		logic               valid;
		logic [16:0]        count;
	} date_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] member_value = '0;
	logic               member_present = 1'b0;
	logic signed [31:0] reference_value = '0;
	logic               reference_active = 1'b0;
	logic               group_last = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [47:0] result_value;
	logic               result_valid;
	logic [16:0]        present_count;

	member_word_t pending_words[$];
	date_result_t date_expect[$];

	// predictor state
	logic [2:0]         mode_now = xsr_pkg::OP_SUM;
	logic signed [47:0] grp_acc = '0;
	logic               grp_seen = 1'b0;
	logic [16:0]        grp_count = '0;

	int  tx_idle = 0;
	int  rx_idle = 0;
	logic rx_hold = 1'b0;
	int  mismatches = 0;

	cross_section_reduce u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.member_value     (member_value),
		.member_present   (member_present),
		.reference_value  (reference_value),
		.reference_active (reference_active),
		.group_last       (group_last),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.result_value     (result_value),
		.result_valid     (result_valid),
		.present_count    (present_count)
	);

	always #5 clk = ~clk;

	function automatic void absorb_word(input member_word_t w);
		longint       s;
		date_result_t r;
		if (w.present) begin
			case (mode_now)
				xsr_pkg::OP_SUM, xsr_pkg::OP_MEAN: begin
					s = longint'(grp_acc) + longint'(w.value);
					if (s > longint'(xsr_pkg::ACC_MAX)) s = longint'(xsr_pkg::ACC_MAX);
					if (s < longint'(xsr_pkg::ACC_MIN)) s = longint'(xsr_pkg::ACC_MIN);
					grp_acc = s[47:0];
				end
				xsr_pkg::OP_MAX: if (!grp_seen || w.value > grp_acc) grp_acc = w.value;
				xsr_pkg::OP_MIN: if (!grp_seen || w.value < grp_acc) grp_acc = w.value;
				xsr_pkg::OP_RANK_DESC:
					if (w.value > w.ref_value && grp_acc < xsr_pkg::ACC_MAX)
						grp_acc = grp_acc + 48'sd1;
				xsr_pkg::OP_RANK_ASC:
					if (w.value < w.ref_value && grp_acc < xsr_pkg::ACC_MAX)
						grp_acc = grp_acc + 48'sd1;
				default: ;
			endcase
			grp_seen = 1'b1;
			if (grp_count != xsr_pkg::COUNT_MAX) grp_count = grp_count + 17'd1;
		end
		if (w.last) begin
			r = '0;
			case (mode_now)
				xsr_pkg::OP_SUM, xsr_pkg::OP_MAX, xsr_pkg::OP_MIN: if (grp_seen) begin
					r.value = grp_acc;
					r.valid = 1'b1;
				end
				xsr_pkg::OP_MEAN: if (grp_seen && grp_count != 0) begin
					s = longint'(grp_acc) / longint'(grp_count);
					r.value = s[47:0];
					r.valid = 1'b1;
				end
				xsr_pkg::OP_RANK_DESC, xsr_pkg::OP_RANK_ASC: if (w.ref_active) begin
					r.value = (grp_acc < xsr_pkg::ACC_MAX) ? grp_acc + 48'sd1
						: xsr_pkg::ACC_MAX;
					r.valid = 1'b1;
				end
				default: ;
			endcase
			r.count = grp_count;
			date_expect.insert(date_expect.size(), r);
			grp_acc = '0;
			grp_seen = 1'b0;
			grp_count = '0;
		end
	endfunction

	// mode register mirror
	always @(posedge clk) begin
		if (!arst_n) begin
			mode_now <= xsr_pkg::OP_SUM;
		end else if (cfg_valid && cfg_ready) begin
			mode_now <= cfg_data;
		end
	end

	// driver: hold the word while stalled, advance on acceptance
	always @(posedge clk) begin
		member_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				absorb_word('{member_value, member_present, reference_value,
					reference_active, group_last});
			if (!in_valid || !in_stall) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle) begin
					w = pending_words.pop_front();
					member_value     <= w.value;
					member_present   <= w.present;
					reference_value  <= w.ref_value;
					reference_active <= w.ref_active;
					group_last       <= w.last;
					in_valid         <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		date_result_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (date_expect.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: value %0d valid %0b count %0d",
							result_value, result_valid, present_count);
				end else begin
					e = date_expect.pop_front();
					if (result_value !== e.value || result_valid !== e.valid ||
					    present_count !== e.count) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp value %0d valid %0b count %0d,",
								" got value %0d valid %0b count %0d"},
								e.value, e.valid, e.count,
								result_value, result_valid, present_count);
					end
				end
			end
			out_stall <= rx_hold || ($urandom_range(99) < rx_idle);
		end
	end

	task automatic push_word(input logic signed [31:0] v, input logic pr,
		input logic signed [31:0] rv, input logic act, input logic last);
		member_word_t w;
		w = '{v, pr, rv, act, last};
		pending_words.insert(pending_words.size(), w);
	endtask

	// wait until every word is in and every result is out, then idle a while
	task automatic drain();
		while (pending_words.size() != 0 || in_valid || date_expect.size() != 0)
			@(negedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_mode(input logic [2:0] m);
		cfg_data  <= m;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return $signed(32'($urandom_range(16))) - 32'sd8;
			4: return $signed(32'($urandom_range(8)) << 16) - 32'sh0004_0000;
			default: return $signed($urandom());
		endcase
	endfunction

	// random dates, mostly short, up to n words
	task automatic fill_dates(input int n);
		int left;
		int len;
		logic signed [31:0] v;
		logic signed [31:0] rv;
		left = n;
		while (left > 0) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1);
			if (len > left) len = left;
			for (int i = 0; i < len; i++) begin
				v  = pick_value();
				rv = ($urandom_range(9) < 3) ? v : pick_value();
				push_word(v, $urandom_range(99) < 80, rv, $urandom_range(99) < 75,
					i == len - 1);
			end
			left -= len;
		end
	endtask

	initial begin
		logic [2:0] m;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sum from reset: extremes cancel to -1, absent word ignored
		@(negedge clk);
		push_word(32'sh7FFF_FFFF, 1'b1, 32'sd0, 1'b0, 1'b0);
		push_word(32'sh1234_5678, 1'b0, 32'sd0, 1'b0, 1'b0);
		push_word(32'sh8000_0000, 1'b1, 32'sd0, 1'b0, 1'b1);
		// date with no present member
		push_word(32'sd5, 1'b0, 32'sd0, 1'b1, 1'b1);
		drain();

		write_mode(xsr_pkg::OP_MEAN);
		@(negedge clk);
		push_word(-32'sd7, 1'b1, 32'sd0, 1'b0, 1'b0);
		push_word(32'sd0, 1'b1, 32'sd0, 1'b0, 1'b1);
		push_word(32'sd9, 1'b0, 32'sd0, 1'b0, 1'b1);
		drain();

		write_mode(xsr_pkg::OP_MAX);
		@(negedge clk);
		push_word(-32'sd5, 1'b1, 32'sd0, 1'b0, 1'b0);
		push_word(32'sh8000_0000, 1'b1, 32'sd0, 1'b0, 1'b0);
		push_word(32'sh7FFF_FFFF, 1'b0, 32'sd0, 1'b0, 1'b1);
		drain();

		write_mode(xsr_pkg::OP_MIN);
		@(negedge clk);
		push_word(32'sh7FFF_FFFF, 1'b1, 32'sd0, 1'b0, 1'b0);
		push_word(32'sd3, 1'b1, 32'sd0, 1'b0, 1'b1);
		drain();

		write_mode(xsr_pkg::OP_RANK_DESC);
		@(negedge clk);
		push_word(32'sd10, 1'b1, 32'sd5, 1'b0, 1'b0);
		push_word(32'sd5, 1'b1, 32'sd5, 1'b0, 1'b0);
		push_word(32'sd1, 1'b0, 32'sd0, 1'b0, 1'b0);
		push_word(32'sd7, 1'b1, 32'sd3, 1'b1, 1'b1);
		// rank before warm-up
		push_word(32'sd7, 1'b1, 32'sd3, 1'b0, 1'b1);
		// rank with no present member
		push_word(32'sd7, 1'b0, 32'sd3, 1'b1, 1'b1);
		drain();

		write_mode(xsr_pkg::OP_RANK_ASC);
		@(negedge clk);
		push_word(32'sh8000_0000, 1'b1, 32'sd0, 1'b0, 1'b0);
		push_word(32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF, 1'b1, 1'b1);
		drain();

		// unknown modes still count present members
		write_mode(3'd6);
		@(negedge clk);
		push_word(32'sd1, 1'b1, 32'sd0, 1'b1, 1'b1);
		drain();
		write_mode(3'd7);
		@(negedge clk);
		push_word(32'sd1, 1'b1, 32'sd0, 1'b1, 1'b0);
		push_word(32'sd2, 1'b1, 32'sd0, 1'b1, 1'b1);
		drain();

		// mode switched inside a date: max opens it, sum closes it
		write_mode(xsr_pkg::OP_MAX);
		@(negedge clk);
		push_word(32'sd100, 1'b1, 32'sd0, 1'b0, 1'b0);
		drain();
		write_mode(xsr_pkg::OP_SUM);
		@(negedge clk);
		push_word(32'sd5, 1'b1, 32'sd0, 1'b0, 1'b1);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle <= (ph == 0) ? 7 : (ph == 1) ? 45 : 0;
			rx_idle <= (ph == 0) ? 45 : (ph == 1) ? 7 : 0;
			for (int k = 0; k < 7; k++) begin
				m = (k == 6) ? 3'($urandom_range(7)) : 3'((k + 2 * ph) % 6);
				write_mode(m);
				@(negedge clk);
				if (ph == 2 && k == 1) begin
					// long output hold while the sender keeps offering
					fork
						begin
							rx_hold <= 1'b1;
							repeat (400) @(posedge clk);
							rx_hold <= 1'b0;
						end
					join_none
				end
				fill_dates(76);
				drain();
			end
		end

		if (mismatches == 0 && date_expect.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#30_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
